@@ hdl/log_spaced_spectrum_peak_binner_unit_assert.svh @@
// assertion macros shared by the checker of the band peak binner
`ifndef LOG_SPACED_SPECTRUM_PEAK_BINNER_UNIT_ASSERT_SVH
`define LOG_SPACED_SPECTRUM_PEAK_BINNER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LSPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LSPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lspb_pkg.sv @@
// types and constants of the log spaced band peak binner
`timescale 1ns / 1ps

package lspb_pkg;

   // band storage limit and the bands in effect
   localparam int MAX_BANDS = 256;
   localparam int BAND_CAP  = (MAX_BANDS < 256) ? MAX_BANDS : 256;

   // field widths
   localparam int MAG_W   = 32;
   localparam int FREQ_W  = 25;
   localparam int BAND_W  = 8;
   localparam int COUNT_W = 9;
   localparam int RATIO_W = 18;
   localparam int CUT_W   = 33;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = CUT_W + RATIO_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CUTOFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_RATIO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_COUNT   = 2'd2;

   // register reset values
   localparam logic [FREQ_W-1:0]  START_CUTOFF_RST = 25'd5120;
   localparam logic [RATIO_W-1:0] CUTOFF_RATIO_RST = 18'd66965;
   localparam logic [COUNT_W-1:0] BAND_COUNT_RST   = 9'd256;

   // command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [FREQ_W-1:0] frequency;
      logic              frame_last;
   } lspb_req_type;

   typedef struct packed {
      logic [BAND_W-1:0] band_index;
      logic [MAG_W-1:0]  band_peak;
      logic              frame_end;
   } lspb_rsp_type;

   // classified item: band in effect after any advance
   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [BAND_W-1:0] band;
      logic              advance;
      logic              last;
   } lspb_cmd_type;

endpackage

@@ hdl/lspb_front.sv @@
// front end: configuration registers, band edge compare and cutoff update
`timescale 1ns / 1ps

module lspb_front import lspb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_push,
   input  lspb_req_type          req_data,
   output logic                  req_full,
   output logic                  cmd_push,
   output lspb_cmd_type          cmd_data,
   input  logic                  cmd_full
);

   logic [FREQ_W-1:0]  start_ff, start_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CUT_W-1:0]   cut_now_ff, cut_now_in;
   logic [CUT_W-1:0]   cut_next_ff, cut_next_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic               refresh_ff, refresh_in;

   logic               accept;
   logic               advance;
   logic [COUNT_W-1:0] band_lim;
   logic [CUT_W-1:0]   start_q16;
   logic [CUT_W-1:0]   mul_op;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-FRAC_W-1:0] prod_sh;
   logic [CUT_W-1:0]   prod_sat;

   // input is blocked while the cutoff is recomputed after reset or a register write
   assign req_full = cmd_full | refresh_ff;
   assign accept   = req_push & ~req_full;

   // bands in effect, clamped to one through the cap
   always_comb begin
      if (count_ff == '0) begin
         band_lim = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(BAND_CAP)) begin
         band_lim = COUNT_W'(BAND_CAP);
      end else begin
         band_lim = count_ff;
      end
   end

   // band edge test in Q25.8
   assign advance = ({req_data.frequency, 8'h00} > cut_now_ff) &&
                    (({1'b0, band_ff} + COUNT_W'(1)) < band_lim);

   // shared cutoff multiplier, registered on the way out
   assign start_q16 = {start_ff, 8'h00};
   always_comb begin
      if (refresh_ff) begin
         mul_op = cut_now_ff;
      end else if (req_data.frame_last) begin
         mul_op = start_q16;
      end else begin
         mul_op = cut_next_ff;
      end
   end
   assign prod     = PROD_W'(mul_op) * PROD_W'(ratio_ff);
   assign prod_sh  = prod[PROD_W-1:FRAC_W];
   assign prod_sat = (|prod_sh[PROD_W-FRAC_W-1:CUT_W]) ? {CUT_W{1'b1}} : prod_sh[CUT_W-1:0];

   // classified item to the queue
   assign cmd_push           = accept;
   assign cmd_data.magnitude = req_data.magnitude;
   assign cmd_data.band      = advance ? band_ff + BAND_W'(1) : band_ff;
   assign cmd_data.advance   = advance;
   assign cmd_data.last      = req_data.frame_last;

   // register writes
   always_comb begin
      start_in   = start_ff;
      ratio_in   = ratio_ff;
      count_in   = count_ff;
      refresh_in = csr_wr_en;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_CUTOFF: start_in = csr_wdata;
            CSR_CUTOFF_RATIO: ratio_in = csr_wdata[RATIO_W-1:0];
            CSR_BAND_COUNT:   count_in = csr_wdata[COUNT_W-1:0];
            default:          ;
         endcase
      end
   end

   // band state: next cutoff on refresh, reload on frame end, step on band advance
   always_comb begin
      cut_now_in  = cut_now_ff;
      cut_next_in = cut_next_ff;
      band_in     = band_ff;
      if (refresh_ff) begin
         cut_next_in = prod_sat;
      end else if (accept) begin
         if (req_data.frame_last) begin
            cut_now_in  = start_q16;
            cut_next_in = prod_sat;
            band_in     = '0;
         end else if (advance) begin
            cut_now_in  = cut_next_ff;
            cut_next_in = prod_sat;
            band_in     = band_ff + BAND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= START_CUTOFF_RST;
         ratio_ff    <= CUTOFF_RATIO_RST;
         count_ff    <= BAND_COUNT_RST;
         cut_now_ff  <= {START_CUTOFF_RST, 8'h00};
         cut_next_ff <= '0;
         band_ff     <= '0;
         refresh_ff  <= 1'b1;
      end else begin
         start_ff    <= start_in;
         ratio_ff    <= ratio_in;
         count_ff    <= count_in;
         cut_now_ff  <= cut_now_in;
         cut_next_ff <= cut_next_in;
         band_ff     <= band_in;
         refresh_ff  <= refresh_in;
      end
   end

endmodule

@@ hdl/lspb_cmd_fifo.sv @@
// short queue of classified items between front and back
`timescale 1ns / 1ps

module lspb_cmd_fifo import lspb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lspb_cmd_type push_data,
   output logic         full,
   input  logic         pop,
   output lspb_cmd_type head,
   output logic         valid
);

   lspb_cmd_type         mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;
   assign head    = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/lspb_back.sv @@
// back end: band peak tracking and the result register
`timescale 1ns / 1ps

module lspb_back import lspb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  lspb_cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output lspb_rsp_type rsp_data
);

   logic [MAG_W-1:0] peak_ff, peak_in;
   logic             phase_ff, phase_in;
   logic             out_valid_ff, out_valid_in;
   lspb_rsp_type     out_ff, out_in;
   logic             can_emit;
   logic [MAG_W-1:0] peak_max;

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;
   assign can_emit  = ~out_valid_ff | rsp_pop;
   assign peak_max  = (cmd.magnitude > peak_ff) ? cmd.magnitude : peak_ff;

   // finished band first, then the frame end result
   always_comb begin
      peak_in      = peak_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      if (cmd_valid) begin
         if (cmd.advance && !phase_ff) begin
            if (can_emit) begin
               out_valid_in       = 1'b1;
               out_in.band_index  = cmd.band - BAND_W'(1);
               out_in.band_peak   = peak_ff;
               out_in.frame_end   = 1'b0;
               peak_in            = cmd.magnitude;
               if (cmd.last) begin
                  phase_in = 1'b1;
               end else begin
                  cmd_pop = 1'b1;
               end
            end
         end else if (cmd.last) begin
            if (can_emit) begin
               out_valid_in       = 1'b1;
               out_in.band_index  = cmd.band;
               out_in.band_peak   = peak_max;
               out_in.frame_end   = 1'b1;
               peak_in            = '0;
               phase_in           = 1'b0;
               cmd_pop            = 1'b1;
            end
         end else begin
            peak_in = peak_max;
            cmd_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         peak_ff      <= peak_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

@@ hdl/log_spaced_spectrum_peak_binner_unit.sv @@
// top level of the log spaced band peak binner
//
//   channel   ports                          accepted when
//   ------    -----------------------------  ---------------------------
//   input     req_push req_full req_data     req_push & ~req_full
//   result    rsp_empty rsp_pop rsp_data     rsp_pop & ~rsp_empty
//   config    csr_wr_en csr_index csr_wdata  csr_wr_en
//
// one item per cycle enters while req_full is low; the front compares against
// a precomputed next cutoff, so the single 33x18 cutoff multiplier never sits
// in the item loop. an item goes through the queue and the result register
// to the result port; an item that closes a band and ends the frame gives two
// results, the closed band first. after reset and after each register write
// req_full is high for one cycle while the next cutoff is recomputed. a stalled
// result side backs up through a four entry queue before req_full rises.
`timescale 1ns / 1ps

module log_spaced_spectrum_peak_binner_unit import lspb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  lspb_req_type          req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output lspb_rsp_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic         cmd_push;
   lspb_cmd_type cmd_in;
   logic         cmd_full;
   logic         cmd_pop;
   lspb_cmd_type cmd_head;
   logic         cmd_valid;

   // classify items and track band edges
   lspb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in),
      .cmd_full  (cmd_full)
   );

   // decoupling queue
   lspb_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .valid     (cmd_valid)
   );

   // peak tracking and results
   lspb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/lspb_checker.sv @@
// port level checks of the band peak binner and their binding
`timescale 1ns / 1ps
`include "log_spaced_spectrum_peak_binner_unit_assert.svh"

module lspb_checker import lspb_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input lspb_rsp_type rsp_data,
   input logic         csr_wr_en
);

   // reset leaves no result and holds off input while the cutoff is rebuilt
   `LSPB_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, rsp_empty && req_full, "bad state after reset")

   // a register write blocks input for the recompute cycle
   `LSPB_ASSERT_NEXT(a_csr_blocks, clock, reset, csr_wr_en, req_full, "input open after register write")

   // a waiting result holds until taken
   `LSPB_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "result changed while stalled")

   // a waiting result carries known values
   `LSPB_ASSERT_NOW(a_rsp_known, clock, reset, !rsp_empty, !$isunknown(rsp_data), "unknown result")

endmodule

bind log_spaced_spectrum_peak_binner_unit lspb_checker u_lspb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .csr_wr_en (csr_wr_en)
);

@@ tb/log_spaced_spectrum_peak_binner_unit_tb.sv @@
// self-checking testbench of the log spaced band peak binner
`timescale 1ns / 1ps

module log_spaced_spectrum_peak_binner_unit_tb;
   import lspb_pkg::*;

   localparam int                CYCLE_LIMIT  = 400000;
   localparam int                RANDOM_ITEMS = 500;
   localparam logic [FREQ_W-1:0] FREQ_TOP     = {FREQ_W{1'b1}};
   localparam logic [MAG_W-1:0]  MAG_TOP      = {MAG_W{1'b1}};
   localparam int                RATIO_TOP    = 262143;
   localparam int                RATIO_ONE    = 65536;

   // tracks band state, predicts finished bands and checks them in order
   class band_peak_checker;
      logic [FREQ_W-1:0]  start_cut;
      logic [RATIO_W-1:0] ratio;
      logic [COUNT_W-1:0] count;
      logic [CUT_W-1:0]   cutoff;
      logic [BAND_W-1:0]  band;
      logic [MAG_W-1:0]   peak;
      lspb_rsp_type       bands_due[$];
      int                 errors;

      function new();
         start_cut = START_CUTOFF_RST;
         ratio     = CUTOFF_RATIO_RST;
         count     = BAND_COUNT_RST;
         errors    = 0;
         reload();
      endfunction

      function void reload();
         cutoff = {start_cut, 8'd0};
         band   = '0;
         peak   = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_START_CUTOFF: start_cut = val[FREQ_W-1:0];
            CSR_CUTOFF_RATIO: ratio = val[RATIO_W-1:0];
            CSR_BAND_COUNT: count = val[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // one accepted sample: band advance, peak update, frame close
      function void take_sample(lspb_req_type item);
         int                lim;
         logic [PROD_W-1:0] wide_cut;
         logic [PROD_W-1:0] prod;
         lspb_rsp_type      res;
         lim = int'(count);
         if (lim < 1) lim = 1;
         if (lim > BAND_CAP) lim = BAND_CAP;
         if ({item.frequency, 8'd0} > cutoff && int'(band) + 1 < lim) begin
            res.band_index = band;
            res.band_peak  = peak;
            res.frame_end  = 1'b0;
            bands_due.push_back(res);
            peak     = '0;
            band     = band + BAND_W'(1);
            wide_cut = PROD_W'(cutoff);
            prod     = (wide_cut * PROD_W'(ratio)) >> FRAC_W;
            cutoff   = (prod > PROD_W'({CUT_W{1'b1}})) ? {CUT_W{1'b1}} : prod[CUT_W-1:0];
         end
         if (item.magnitude > peak) peak = item.magnitude;
         if (item.frame_last) begin
            res.band_index = band;
            res.band_peak  = peak;
            res.frame_end  = 1'b1;
            bands_due.push_back(res);
            reload();
         end
      endfunction

      function void check_band(lspb_rsp_type got);
         lspb_rsp_type want;
         if (bands_due.size() == 0) begin
            $error("unexpected item: band_index %0d band_peak %0d frame_end %0b",
                   got.band_index, got.band_peak, got.frame_end);
            errors++;
            return;
         end
         want = bands_due.pop_front();
         if (got.band_index !== want.band_index) begin
            $error("band_index: expected %0d, actual %0d", want.band_index, got.band_index);
            errors++;
         end
         if (got.band_peak !== want.band_peak) begin
            $error("band_peak: expected %0d, actual %0d", want.band_peak, got.band_peak);
            errors++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
            errors++;
         end
      endfunction

      function int pending();
         return bands_due.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   logic                  req_full;
   lspb_req_type          req_data  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   lspb_rsp_type          rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_START_CUTOFF;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   band_peak_checker tracker;
   bit               calm = 1'b0;
   int               items_sent = 0;
   int               cycles = 0;

   log_spaced_spectrum_peak_binner_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // accepted items on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) tracker.take_sample(req_data);
         if (rsp_pop && !rsp_empty) tracker.check_band(rsp_data);
      end
   end

   // result side: pop with random stalls, none while calm
   initial begin : pop_drive
      int stall;
      int r;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop = 1'b0;
            stall--;
         end else begin
            rsp_pop = 1'b1;
            if (!calm) begin
               r = $urandom_range(0, 99);
               if (r < 12) stall = $urandom_range(1, 3);
               else if (r < 15) stall = $urandom_range(10, 40);
            end
         end
      end
   end

   function automatic int idle_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [MAG_W-1:0] rand_mag();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return MAG_TOP;
      if (r == 2) return $urandom_range(0, 255);
      return $urandom;
   endfunction

   // push one item, called and returning just after a falling edge
   task automatic send_item(input logic [MAG_W-1:0] mag, input logic [FREQ_W-1:0] freq,
                            input logic last);
      int gap;
      gap = idle_gap();
      repeat (gap) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_data = {mag, freq, last};
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      items_sent++;
      @(negedge clock);
   endtask

   // wait for all bands, then let items with no result leave the pipeline
   task automatic wait_idle();
      req_push = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (32) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(val);
      tracker.set_reg(idx, CSR_DATA_W'(val));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // rising frequencies with random content, closed by a last item
   task automatic send_frame();
      int n;
      int step;
      int freq;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      step = ($urandom_range(0, int'(FREQ_TOP)) >> $urandom_range(0, 18)) / n + 1;
      freq = $urandom_range(0, step);
      for (int k = 0; k < n; k++) begin
         send_item(rand_mag(), freq[FREQ_W-1:0], k == n - 1);
         freq += $urandom_range(0, 2 * step);
         if (freq > int'(FREQ_TOP)) freq = int'(FREQ_TOP);
      end
   endtask

   // loose items, sometimes ending a frame early
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         send_item(rand_mag(),
                   FREQ_W'($urandom_range(0, int'(FREQ_TOP)) >> $urandom_range(0, 20)),
                   $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic random_config(input int phase);
      int sc;
      int ra;
      int bc;
      case ($urandom_range(0, 3))
         0: sc = 0;
         1: sc = int'(FREQ_TOP);
         2: sc = $urandom_range(0, int'(FREQ_TOP));
         default: sc = $urandom_range(64, 65536);
      endcase
      case ($urandom_range(0, 4))
         0: ra = RATIO_ONE;
         1: ra = RATIO_TOP;
         2: ra = $urandom_range(RATIO_ONE, RATIO_TOP);
         3: ra = $urandom_range(RATIO_ONE, 80000);
         default: ra = $urandom_range(0, RATIO_ONE - 1);
      endcase
      case ($urandom_range(0, 4))
         0: bc = $urandom_range(0, 511);
         1: bc = $urandom_range(1, 8);
         2: bc = 256;
         3: bc = $urandom_range(200, 256);
         default: bc = 1;
      endcase
      // first phases pin the extremes and the reset settings
      case (phase)
         0: begin sc = int'(FREQ_TOP); ra = RATIO_TOP; bc = 511; end
         1: begin sc = 0; ra = RATIO_ONE; bc = 1; end
         2: begin sc = 256; ra = $urandom_range(0, RATIO_ONE - 1); bc = 2; end
         3: begin sc = 5120; ra = 66965; bc = 256; end
         default: ;
      endcase
      if (phase < 4 || $urandom_range(0, 2) != 0) write_csr(CSR_START_CUTOFF, sc);
      if (phase < 4 || $urandom_range(0, 2) != 0) write_csr(CSR_CUTOFF_RATIO, ra);
      if (phase < 4 || $urandom_range(0, 2) != 0) write_csr(CSR_BAND_COUNT, bc);
   endtask

   initial begin : stimulus
      int phase;
      int phase_start;
      tracker = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: cutoff equality, advance, advance with frame end
      send_item('0, '0, 1'b0);
      send_item(MAG_TOP, 25'd5120, 1'b0);
      send_item(32'd5, 25'd5121, 1'b0);
      send_item(32'd7, FREQ_TOP, 1'b0);
      send_item(32'd9, FREQ_TOP, 1'b1);
      send_item('0, '0, 1'b1);
      send_item(MAG_TOP, '0, 1'b1);

      // two bands: one advance, then the rest folds into the last band
      wait_idle();
      write_csr(CSR_BAND_COUNT, 2);
      send_item(32'd1, FREQ_TOP, 1'b0);
      send_item(32'd2, FREQ_TOP, 1'b0);
      send_item(32'd3, FREQ_TOP, 1'b1);

      // band count zero acts as one
      wait_idle();
      write_csr(CSR_BAND_COUNT, 0);
      send_item(32'd4, FREQ_TOP, 1'b0);
      send_item(32'd1, FREQ_TOP, 1'b1);

      // count above the cap, zero ratio collapses the cutoff to zero
      wait_idle();
      write_csr(CSR_BAND_COUNT, 511);
      write_csr(CSR_CUTOFF_RATIO, 0);
      write_csr(CSR_START_CUTOFF, 0);
      send_item(32'd3, 25'd1, 1'b0);
      send_item(32'd2, 25'd1, 1'b1);

      // saturating cutoff product
      wait_idle();
      write_csr(CSR_CUTOFF_RATIO, RATIO_TOP);
      write_csr(CSR_START_CUTOFF, 1 << 24);
      send_item(32'd1, FREQ_TOP, 1'b0);
      send_item(32'd2, FREQ_TOP, 1'b0);
      send_item(32'd3, FREQ_TOP, 1'b1);

      // start cutoff written mid-frame waits for the frame end
      wait_idle();
      write_csr(CSR_CUTOFF_RATIO, RATIO_ONE);
      write_csr(CSR_START_CUTOFF, 256);
      send_item(32'd9, '0, 1'b1);
      send_item(32'd5, '0, 1'b0);
      wait_idle();
      write_csr(CSR_START_CUTOFF, 0);
      send_item(32'd6, 25'd300, 1'b0);
      send_item(32'd7, 25'd1, 1'b1);
      send_item(32'd8, 25'd1, 1'b1);

      // random phases, each under its own settings
      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         wait_idle();
         random_config(phase);
         calm = ($urandom_range(0, 3) == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < 50) begin
            if ($urandom_range(0, 99) < 80) send_frame();
            else send_noise();
         end
         phase++;
      end

      calm = 1'b0;
      wait_idle();
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
